// ----- hdl/cb_pkg.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker package
// Shared types, codes and sizes for the circuit breaker block and its checker.
// ----------------------------------------------------------------------------
package cb_pkg;

    // Sizes of the outcome history ring and of event timestamps, and the trip-rate constants.
    localparam int HIST_DEPTH  = 64;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int MIN_HISTORY = 10;
    localparam int TIME_BITS   = 48;
    localparam int RATE_SCALE  = 100;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FAIL_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_FAIL_RATE   = 3'd1;
    localparam logic [2:0] CFG_OPEN_HOLD   = 3'd2;
    localparam logic [2:0] CFG_CLOSE_LIMIT = 3'd3;
    localparam logic [2:0] CFG_PROBE_LIMIT = 3'd4;
    localparam logic [2:0] CFG_WINDOW      = 3'd5;

    // Event operation codes.
    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_SUCCESS = 3'd1;
    localparam logic [2:0] OP_FAILURE = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_FORCE   = 3'd4;
    localparam logic [2:0] OP_RESET   = 3'd5;

    // Breaker states.
    typedef enum logic [1:0] {
        BRK_CLOSED = 2'd0,
        BRK_OPEN   = 2'd1,
        BRK_HALF   = 2'd2
    } brk_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DROP_RD,
        S_DROP,
        S_PUSH,
        S_POP_RD,
        S_POP_CHK,
        S_DECIDE,
        S_DONE
    } seq_state_t;

    // Event beat.
    typedef struct packed {
        logic [2:0]           operation;
        logic [TIME_BITS-1:0] now_ms;
        logic [1:0]           forced_state;
    } cb_evt_t;

    // Result beat.
    typedef struct packed {
        logic        allowed;
        logic [1:0]  breaker_state;
        logic [6:0]  window_entries;
        logic [6:0]  window_failures;
        logic [15:0] fail_streak;
        logic [15:0] success_streak;
        logic [31:0] requests_seen;
        logic [31:0] successes_seen;
        logic [31:0] failures_seen;
        logic [31:0] rejections_seen;
        logic [31:0] timeouts_seen;
        logic [31:0] transitions_seen;
    } cb_res_t;

    // One entry of the outcome history.
    typedef struct packed {
        logic [TIME_BITS-1:0] stamp;
        logic                 ok;
    } hist_entry_t;

endpackage

// ----- hdl/circuit_breaker_fsm.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker state machine
// Closed / open / half-open breaker driven by timestamped events, with a
// time-windowed outcome history and wrapping statistics counters.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Beat
//   --------  -------------------  ------------------------------------------
//   evt       evt_valid/evt_stall  one event: operation, timestamp, target
//   res       res_valid/res_stall  one result per event: state and counters
//   cfg       cfg_valid/cfg_ready  register index and write data
//
// Requests, forces, resets and unknown operations go from S_EXEC straight to S_DONE.
// Success, failure and timeout go on through S_PUSH, preceded by S_DROP_RD and
// S_DROP when the history ring is full, then, when the timestamp is not below
// the window, through the S_POP_RD / S_POP_CHK expiry loop, which reads one
// entry at a time through the single registered read port of the history
// memory, and finally through S_DECIDE and S_DONE.
// The block takes no new event until the result of the last one is loaded
// into the output register; a stalled result only holds the block at the end
// of the next event. Reset restores the register defaults and empties the
// history; the history memory itself is not cleared.
//
module circuit_breaker_fsm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           evt_valid,
    output logic           evt_stall,
    input  cb_pkg::cb_evt_t evt_data,
    output logic           res_valid,
    input  logic           res_stall,
    output cb_pkg::cb_res_t res_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import cb_pkg::*;

    // Statistics counter slots.
    localparam int STAT_COUNT = 6;
    localparam int C_REQ      = 0;
    localparam int C_SUC      = 1;
    localparam int C_FAIL     = 2;
    localparam int C_REJ      = 3;
    localparam int C_TMO      = 4;
    localparam int C_TRANS    = 5;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Configuration registers.
    logic [15:0] fail_limit_reg;
    logic [6:0]  fail_rate_reg;
    logic [31:0] open_hold_reg;
    logic [15:0] close_limit_reg;
    logic [15:0] probe_limit_reg;
    logic [31:0] window_reg;

    // Sequencer and latched event.
    seq_state_t           seq_reg, seq_next;
    logic [2:0]           op_reg, op_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [1:0]           tgt_reg, tgt_next;
    logic                 allowed_reg, allowed_next;

    // Breaker state.
    brk_t                 brk_reg, brk_next;
    logic [15:0]          fail_run_reg, fail_run_next;
    logic [15:0]          succ_run_reg, succ_run_next;
    logic [15:0]          probe_reg, probe_next;
    logic [TIME_BITS-1:0] last_change_reg, last_change_next;
    logic [31:0]          stat_reg [STAT_COUNT];
    logic [31:0]          stat_next [STAT_COUNT];

    // History ring bookkeeping.
    logic [HIST_AW-1:0]   head_reg, head_next;
    logic [HIST_AW:0]     count_reg, count_next;
    logic [HIST_AW:0]     fcount_reg, fcount_next;

    // Result register.
    logic                 res_valid_reg, res_valid_next;
    cb_res_t              res_data_reg, res_data_next;

    // History memory.
    hist_entry_t          hist_mem [HIST_DEPTH];
    hist_entry_t          rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [HIST_AW-1:0]   mem_waddr;
    hist_entry_t          mem_wdata;

    // Combinational helpers.
    logic                 go_en;
    brk_t                 go_tgt;
    logic                 probe_one;
    logic                 is_ok;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] cutoff;
    logic [13:0]          rate_lhs;
    logic [13:0]          rate_rhs;
    logic                 trip;

    assign cfg_ready = 1'b1;
    assign evt_stall = (seq_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign is_ok    = (op_reg == OP_SUCCESS);
    assign elapsed  = (now_reg >= last_change_reg) ? now_reg - last_change_reg
                                                   : '0;
    assign cutoff   = now_reg - TIME_BITS'(window_reg);
    assign rate_lhs = 14'(fcount_reg) * 14'(RATE_SCALE);
    assign rate_rhs = 14'(fail_rate_reg) * 14'(count_reg);
    assign trip     = (fail_run_reg >= fail_limit_reg) ||
                      ((count_reg >= (HIST_AW + 1)'(MIN_HISTORY)) &&
                       (rate_lhs >= rate_rhs));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg  <= 16'd5;
            fail_rate_reg   <= 7'd50;
            open_hold_reg   <= 32'd30000;
            close_limit_reg <= 16'd3;
            probe_limit_reg <= 16'd3;
            window_reg      <= 32'd60000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FAIL_LIMIT:  fail_limit_reg  <= cfg_data[15:0];
                CFG_FAIL_RATE:   fail_rate_reg   <= cfg_data[6:0];
                CFG_OPEN_HOLD:   open_hold_reg   <= cfg_data;
                CFG_CLOSE_LIMIT: close_limit_reg <= cfg_data[15:0];
                CFG_PROBE_LIMIT: probe_limit_reg <= cfg_data[15:0];
                CFG_WINDOW:      window_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    // History memory: one write port, one registered read port at the head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= hist_mem[head_reg];
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= S_IDLE;
            brk_reg         <= BRK_CLOSED;
            fail_run_reg    <= '0;
            succ_run_reg    <= '0;
            probe_reg       <= '0;
            last_change_reg <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            fcount_reg      <= '0;
            res_valid_reg   <= 1'b0;
            for (int i = 0; i < STAT_COUNT; i++)
            begin
                stat_reg[i] <= '0;
            end
        end
        else
        begin
            seq_reg         <= seq_next;
            brk_reg         <= brk_next;
            fail_run_reg    <= fail_run_next;
            succ_run_reg    <= succ_run_next;
            probe_reg       <= probe_next;
            last_change_reg <= last_change_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            fcount_reg      <= fcount_next;
            res_valid_reg   <= res_valid_next;
            for (int i = 0; i < STAT_COUNT; i++)
            begin
                stat_reg[i] <= stat_next[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        tgt_reg      <= tgt_next;
        allowed_reg  <= allowed_next;
        res_data_reg <= res_data_next;
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        seq_next         = seq_reg;
        op_next          = op_reg;
        now_next         = now_reg;
        tgt_next         = tgt_reg;
        allowed_next     = allowed_reg;
        brk_next         = brk_reg;
        fail_run_next    = fail_run_reg;
        succ_run_next    = succ_run_reg;
        probe_next       = probe_reg;
        last_change_next = last_change_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        fcount_next      = fcount_reg;
        res_data_next    = res_data_reg;
        for (int i = 0; i < STAT_COUNT; i++)
        begin
            stat_next[i] = stat_reg[i];
        end
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = head_reg + count_reg[HIST_AW-1:0];
        mem_wdata = '{stamp: now_reg, ok: is_ok};
        go_en     = 1'b0;
        go_tgt    = brk_reg;
        probe_one = 1'b0;

        // A taken result empties the output register.
        res_valid_next = res_valid_reg && res_stall;

        case (seq_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    op_next      = evt_data.operation;
                    now_next     = evt_data.now_ms;
                    tgt_next     = evt_data.forced_state;
                    allowed_next = 1'b0;
                    seq_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                seq_next = S_DONE;
                case (op_reg)
                    OP_REQUEST:
                    begin
                        stat_next[C_REQ] = stat_reg[C_REQ] + 32'd1;
                        case (brk_reg)
                            BRK_CLOSED:
                            begin
                                allowed_next = 1'b1;
                            end
                            BRK_OPEN:
                            begin
                                if (elapsed >= TIME_BITS'(open_hold_reg))
                                begin
                                    go_en        = 1'b1;
                                    go_tgt       = BRK_HALF;
                                    probe_one    = 1'b1;
                                    allowed_next = 1'b1;
                                end
                                else
                                begin
                                    stat_next[C_REJ] = stat_reg[C_REJ] + 32'd1;
                                end
                            end
                            default:
                            begin
                                if (probe_reg < probe_limit_reg)
                                begin
                                    probe_next   = probe_reg + 16'd1;
                                    allowed_next = 1'b1;
                                end
                                else
                                begin
                                    stat_next[C_REJ] = stat_reg[C_REJ] + 32'd1;
                                end
                            end
                        endcase
                    end
                    OP_SUCCESS:
                    begin
                        stat_next[C_SUC] = stat_reg[C_SUC] + 32'd1;
                        succ_run_next    = sat_inc16(succ_run_reg);
                        fail_run_next    = '0;
                        seq_next = (count_reg == (HIST_AW + 1)'(HIST_DEPTH)) ? S_DROP_RD
                                                                           : S_PUSH;
                    end
                    OP_FAILURE, OP_TIMEOUT:
                    begin
                        stat_next[C_FAIL] = stat_reg[C_FAIL] + 32'd1;
                        if (op_reg == OP_TIMEOUT)
                        begin
                            stat_next[C_TMO] = stat_reg[C_TMO] + 32'd1;
                        end
                        fail_run_next = sat_inc16(fail_run_reg);
                        succ_run_next = '0;
                        seq_next = (count_reg == (HIST_AW + 1)'(HIST_DEPTH)) ? S_DROP_RD
                                                                           : S_PUSH;
                    end
                    OP_FORCE:
                    begin
                        if (tgt_reg <= 2'(BRK_HALF))
                        begin
                            go_en  = 1'b1;
                            go_tgt = brk_t'(tgt_reg);
                        end
                    end
                    OP_RESET:
                    begin
                        brk_next         = BRK_CLOSED;
                        fail_run_next    = '0;
                        succ_run_next    = '0;
                        probe_next       = '0;
                        head_next        = '0;
                        count_next       = '0;
                        fcount_next      = '0;
                        last_change_next = now_reg;
                        for (int i = 0; i < STAT_COUNT; i++)
                        begin
                            stat_next[i] = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Full ring: read the oldest entry, then drop it.
            S_DROP_RD:
            begin
                mem_re   = 1'b1;
                seq_next = S_DROP;
            end

            S_DROP:
            begin
                if (!rd_data_reg.ok)
                begin
                    fcount_next = fcount_reg - 1'b1;
                end
                head_next  = head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                seq_next   = S_PUSH;
            end

            // Store the new outcome behind the newest entry.
            S_PUSH:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                if (!is_ok)
                begin
                    fcount_next = fcount_reg + 1'b1;
                end
                seq_next = (now_reg >= TIME_BITS'(window_reg)) ? S_POP_RD : S_DECIDE;
            end

            // Expiry loop: read the head, pop it while older than the cutoff.
            S_POP_RD:
            begin
                mem_re   = 1'b1;
                seq_next = (count_reg == '0) ? S_DECIDE : S_POP_CHK;
            end

            S_POP_CHK:
            begin
                if (rd_data_reg.stamp < cutoff)
                begin
                    if (!rd_data_reg.ok)
                    begin
                        fcount_next = fcount_reg - 1'b1;
                    end
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    seq_next   = S_POP_RD;
                end
                else
                begin
                    seq_next = S_DECIDE;
                end
            end

            // Trip or close on the updated streaks and window.
            S_DECIDE:
            begin
                seq_next = S_DONE;
                if (is_ok)
                begin
                    if (brk_reg == BRK_HALF && succ_run_reg >= close_limit_reg)
                    begin
                        go_en  = 1'b1;
                        go_tgt = BRK_CLOSED;
                    end
                end
                else if (brk_reg == BRK_CLOSED)
                begin
                    if (trip)
                    begin
                        go_en  = 1'b1;
                        go_tgt = BRK_OPEN;
                    end
                end
                else if (brk_reg == BRK_HALF)
                begin
                    go_en  = 1'b1;
                    go_tgt = BRK_OPEN;
                end
            end

            // Load the result once the output register is free.
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next                 = 1'b1;
                    res_data_next.allowed          = allowed_reg;
                    res_data_next.breaker_state    = brk_reg;
                    res_data_next.window_entries   = count_reg;
                    res_data_next.window_failures  = fcount_reg;
                    res_data_next.fail_streak      = fail_run_reg;
                    res_data_next.success_streak   = succ_run_reg;
                    res_data_next.requests_seen    = stat_reg[C_REQ];
                    res_data_next.successes_seen   = stat_reg[C_SUC];
                    res_data_next.failures_seen    = stat_reg[C_FAIL];
                    res_data_next.rejections_seen  = stat_reg[C_REJ];
                    res_data_next.timeouts_seen    = stat_reg[C_TMO];
                    res_data_next.transitions_seen = stat_reg[C_TRANS];
                    seq_next                       = S_IDLE;
                end
            end

            default:
            begin
                seq_next = S_IDLE;
            end
        endcase

        // State change: count it, stamp it and clear what the new state starts.
        if (go_en && go_tgt != brk_reg)
        begin
            brk_next           = go_tgt;
            stat_next[C_TRANS] = stat_reg[C_TRANS] + 32'd1;
            last_change_next   = now_reg;
            if (go_tgt == BRK_HALF)
            begin
                probe_next    = '0;
                succ_run_next = '0;
            end
            else if (go_tgt == BRK_CLOSED)
            begin
                fail_run_next = '0;
            end
        end

        // The request that enters half-open is the first probe.
        if (probe_one)
        begin
            probe_next = 16'd1;
        end
    end

endmodule

// ----- hdl/cb_checker.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker port checker
// Watches the breaker's ports and flags beats that break its behavior.
// ----------------------------------------------------------------------------
module cb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            evt_valid,
    input logic            evt_stall,
    input logic            res_valid,
    input logic            res_stall,
    input cb_pkg::cb_res_t res_data
);
    import cb_pkg::*;

    // A held result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped while stalled");

    // A held result keeps its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("result beat changed while stalled");

    // An accepted event keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall |=> evt_stall)
        else $error("event taken while the previous one is still in work");

    // The reported state is always a real breaker state.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.breaker_state != 2'd3)
        else $error("result reports an undefined breaker state");

    // Windowed failures never exceed the entries, which never exceed the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.window_failures <= res_data.window_entries) &&
                      (res_data.window_entries <= 7'(HIST_DEPTH)))
        else $error("window occupancy out of range");

endmodule

bind circuit_breaker_fsm cb_checker u_cb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Circuit breaker testbench
// Drives timestamped events into the breaker and compares every result beat
// with a cycle-free model of the breaker kept inside the bench. A short
// table of directed events runs first, then phases of random events, each
// under its own register settings and one of the shared idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

    import cb_pkg::*;

    // Operation codes the block must ignore, and the unused force target.
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;
    localparam logic [1:0] FORCE_BAD  = 2'd3;

    // Register indexes that decode to nothing.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 160;

    // One row of the directed table with the allowed flag and state it must give.
    typedef struct packed {
        logic [2:0]           op;
        logic [TIME_BITS-1:0] stamp;
        logic [1:0]           target;
        logic                 allow;
        brk_t                 state;
    } plan_row_t;

    localparam int PLAN_ROWS = 25;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{OP_REQUEST, 48'd0,               BRK_CLOSED, 1'b1, BRK_CLOSED},
        '{OP_FORCE,   48'd10,              FORCE_BAD,  1'b0, BRK_CLOSED},
        '{OP_UNUSED6, 48'd20,              BRK_OPEN,   1'b0, BRK_CLOSED},
        '{OP_UNUSED7, 48'd30,              BRK_HALF,   1'b0, BRK_CLOSED},
        '{OP_SUCCESS, 48'd100,             BRK_CLOSED, 1'b0, BRK_CLOSED},
        '{OP_FAILURE, 48'd200,             BRK_CLOSED, 1'b0, BRK_CLOSED},
        '{OP_FAILURE, 48'd300,             BRK_CLOSED, 1'b0, BRK_CLOSED},
        '{OP_FAILURE, 48'd400,             BRK_CLOSED, 1'b0, BRK_CLOSED},
        '{OP_FAILURE, 48'd500,             BRK_CLOSED, 1'b0, BRK_CLOSED},
        '{OP_FAILURE, 48'd600,             BRK_CLOSED, 1'b0, BRK_OPEN},
        '{OP_REQUEST, 48'd1000,            BRK_CLOSED, 1'b0, BRK_OPEN},
        '{OP_REQUEST, 48'd30600,           BRK_CLOSED, 1'b1, BRK_HALF},
        '{OP_REQUEST, 48'd30610,           BRK_CLOSED, 1'b1, BRK_HALF},
        '{OP_REQUEST, 48'd30620,           BRK_CLOSED, 1'b1, BRK_HALF},
        '{OP_REQUEST, 48'd30630,           BRK_CLOSED, 1'b0, BRK_HALF},
        '{OP_TIMEOUT, 48'd30700,           BRK_CLOSED, 1'b0, BRK_OPEN},
        '{OP_FORCE,   48'd30800,           BRK_HALF,   1'b0, BRK_HALF},
        '{OP_SUCCESS, 48'd30900,           BRK_CLOSED, 1'b0, BRK_HALF},
        '{OP_SUCCESS, 48'd31000,           BRK_CLOSED, 1'b0, BRK_HALF},
        '{OP_SUCCESS, 48'd31100,           BRK_CLOSED, 1'b0, BRK_CLOSED},
        '{OP_FORCE,   48'hFFFF_FFFF_FFFF,  BRK_OPEN,   1'b0, BRK_OPEN},
        '{OP_REQUEST, 48'd0,               BRK_CLOSED, 1'b0, BRK_OPEN},
        '{OP_FORCE,   48'd1,               BRK_OPEN,   1'b0, BRK_OPEN},
        '{OP_RESET,   48'd5,               BRK_HALF,   1'b0, BRK_CLOSED},
        '{OP_REQUEST, 48'd6,               BRK_CLOSED, 1'b1, BRK_CLOSED}
    };

    // Block ports.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        evt_valid = 1'b0;
    logic        evt_stall;
    cb_evt_t     evt_data  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    cb_res_t     res_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Breaker model: register copies.
    logic [15:0] lim_fail;
    logic [6:0]  lim_rate;
    logic [31:0] hold_ms;
    logic [15:0] lim_close;
    logic [15:0] lim_probe;
    logic [31:0] win_ms;

    // Breaker model: state.
    brk_t                 pr_state;
    logic [15:0]          pr_fail_run;
    logic [15:0]          pr_succ_run;
    logic [15:0]          pr_probes;
    logic [TIME_BITS-1:0] pr_last_change;
    logic [TIME_BITS-1:0] ring_stamp [HIST_DEPTH];
    logic                 ring_ok    [HIST_DEPTH];
    int                   ring_head;
    int                   ring_cnt;
    int                   ring_fails;
    logic [31:0]          n_req, n_succ, n_fail, n_rej, n_tmo, n_trans;

    // Expected result beats, oldest first.
    cb_res_t pending_results [$];

    // Run bookkeeping.
    int mismatches      = 0;
    int events_sent     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;
    int opens           = 0;
    int half_entries    = 0;
    int closes          = 0;
    int full_drops      = 0;
    int expired_pops    = 0;
    int send_gap_pct    = 0;
    int stall_pct       = 0;

    // Random event generation state.
    logic [TIME_BITS-1:0] clock_ms = 48'd100;
    logic [31:0]          tick;
    logic [31:0]          phase_regs [6];

    circuit_breaker_fsm u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Breaker model
    // ------------------------------------------------------------------------

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Clear state, history and statistics; the timestamp marks a state change.
    function automatic void clear_breaker(input logic [TIME_BITS-1:0] stamp);
        pr_state       = BRK_CLOSED;
        pr_fail_run    = '0;
        pr_succ_run    = '0;
        pr_probes      = '0;
        pr_last_change = stamp;
        ring_head      = 0;
        ring_cnt       = 0;
        ring_fails     = 0;
        n_req          = '0;
        n_succ         = '0;
        n_fail         = '0;
        n_rej          = '0;
        n_tmo          = '0;
        n_trans        = '0;
    endfunction

    function automatic void ring_pop();
        if (ring_cnt == 0)
            return;
        if (!ring_ok[ring_head])
            ring_fails--;
        ring_head = (ring_head + 1) % HIST_DEPTH;
        ring_cnt--;
    endfunction

    // Push one outcome, dropping the oldest when full, then expire old entries.
    function automatic void ring_push(input logic [TIME_BITS-1:0] stamp, input logic ok);
        int                   slot;
        logic [TIME_BITS-1:0] cutoff;
        if (ring_cnt >= HIST_DEPTH)
        begin
            ring_pop();
            full_drops++;
        end
        slot = (ring_head + ring_cnt) % HIST_DEPTH;
        ring_stamp[slot] = stamp;
        ring_ok[slot]    = ok;
        ring_cnt++;
        if (!ok)
            ring_fails++;
        if (stamp >= TIME_BITS'(win_ms))
        begin
            cutoff = stamp - TIME_BITS'(win_ms);
            while (ring_cnt > 0 && ring_stamp[ring_head] < cutoff)
            begin
                ring_pop();
                expired_pops++;
            end
        end
    endfunction

    function automatic void move_to(input brk_t target, input logic [TIME_BITS-1:0] stamp);
        if (pr_state == target)
            return;
        pr_state       = target;
        n_trans        = n_trans + 32'd1;
        pr_last_change = stamp;
        if (target == BRK_HALF)
        begin
            pr_probes   = '0;
            pr_succ_run = '0;
            half_entries++;
        end
        else if (target == BRK_CLOSED)
        begin
            pr_fail_run = '0;
            closes++;
        end
        else
            opens++;
    endfunction

    // Failure or timeout outcome: streak trip, rate trip, or half-open reopen.
    function automatic void record_failure(input logic [TIME_BITS-1:0] stamp);
        logic trip;
        n_fail      = n_fail + 32'd1;
        pr_fail_run = sat16(pr_fail_run);
        pr_succ_run = '0;
        ring_push(stamp, 1'b0);
        if (pr_state == BRK_CLOSED)
        begin
            trip = (pr_fail_run >= lim_fail);
            if (!trip && ring_cnt >= MIN_HISTORY &&
                ring_fails * RATE_SCALE >= int'(lim_rate) * ring_cnt)
                trip = 1'b1;
            if (trip)
                move_to(BRK_OPEN, stamp);
        end
        else if (pr_state == BRK_HALF)
            move_to(BRK_OPEN, stamp);
    endfunction

    // Request gate: closed passes, open waits out the hold, half-open counts probes.
    function automatic logic handle_request(input logic [TIME_BITS-1:0] stamp);
        logic [TIME_BITS-1:0] elapsed;
        n_req = n_req + 32'd1;
        if (pr_state == BRK_CLOSED)
            return 1'b1;
        if (pr_state == BRK_OPEN)
        begin
            elapsed = (stamp >= pr_last_change) ? stamp - pr_last_change : '0;
            if (elapsed >= TIME_BITS'(hold_ms))
            begin
                move_to(BRK_HALF, stamp);
                pr_probes = 16'd1;
                return 1'b1;
            end
            n_rej = n_rej + 32'd1;
            return 1'b0;
        end
        if (pr_probes < lim_probe)
        begin
            pr_probes = pr_probes + 16'd1;
            return 1'b1;
        end
        n_rej = n_rej + 32'd1;
        return 1'b0;
    endfunction

    // Advance the model by one accepted event and build the result it must give.
    function automatic cb_res_t next_breaker_result(input cb_evt_t ev);
        cb_res_t r;
        logic    pass;
        pass = 1'b0;
        case (ev.operation)
            OP_REQUEST: pass = handle_request(ev.now_ms);
            OP_SUCCESS:
            begin
                n_succ      = n_succ + 32'd1;
                pr_succ_run = sat16(pr_succ_run);
                pr_fail_run = '0;
                ring_push(ev.now_ms, 1'b1);
                if (pr_state == BRK_HALF && pr_succ_run >= lim_close)
                    move_to(BRK_CLOSED, ev.now_ms);
            end
            OP_FAILURE: record_failure(ev.now_ms);
            OP_TIMEOUT:
            begin
                n_tmo = n_tmo + 32'd1;
                record_failure(ev.now_ms);
            end
            OP_FORCE:
            begin
                if (ev.forced_state != FORCE_BAD)
                    move_to(brk_t'(ev.forced_state), ev.now_ms);
            end
            OP_RESET: clear_breaker(ev.now_ms);
            default: ;
        endcase
        r.allowed          = pass;
        r.breaker_state    = pr_state;
        r.window_entries   = 7'(ring_cnt);
        r.window_failures  = 7'(ring_fails);
        r.fail_streak      = pr_fail_run;
        r.success_streak   = pr_succ_run;
        r.requests_seen    = n_req;
        r.successes_seen   = n_succ;
        r.failures_seen    = n_fail;
        r.rejections_seen  = n_rej;
        r.timeouts_seen    = n_tmo;
        r.transitions_seen = n_trans;
        return r;
    endfunction

    // Register write as the block sees it: each register keeps its low bits.
    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_FAIL_LIMIT:  lim_fail  = data[15:0];
            CFG_FAIL_RATE:   lim_rate  = data[6:0];
            CFG_OPEN_HOLD:   hold_ms   = data;
            CFG_CLOSE_LIMIT: lim_close = data[15:0];
            CFG_PROBE_LIMIT: lim_probe = data[15:0];
            CFG_WINDOW:      win_ms    = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    // Offer one event beat and, once it is taken, queue the result it must give.
    // Valid is left high; the next beat or an explicit pause lowers it.
    task automatic send_event(input cb_evt_t ev, input logic pin,
                              input logic pin_allow, input brk_t pin_state);
        cb_res_t want;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt_data  <= ev;
        do
            @(posedge clk);
        while (evt_stall);
        want = next_breaker_result(ev);
        if (pin)
        begin
            want.allowed       = pin_allow;
            want.breaker_state = pin_state;
        end
        pending_results.insert(pending_results.size(), want);
        events_sent++;
        @(negedge clk);
    endtask

    // Hold off new events until every queued result has been taken.
    task automatic wait_drained();
        evt_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Write all six registers, plus one write to an unused index when asked.
    task automatic write_regs(input logic spare);
        int n;
        n = spare ? 7 : 6;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            if (i < 6)
            begin
                cfg_index <= 3'(i);
                cfg_data  <= phase_regs[i];
            end
            else
            begin
                cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
                cfg_data  <= $urandom();
            end
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_reg(cfg_index, cfg_data);
            reg_writes++;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Register settings of one phase: small values, zeros, maxima, then random.
    task automatic load_phase_regs(input int p);
        case (p)
            0:
            begin
                phase_regs[CFG_FAIL_LIMIT]  = 32'd3;
                phase_regs[CFG_FAIL_RATE]   = 32'd50;
                phase_regs[CFG_OPEN_HOLD]   = 32'd200;
                phase_regs[CFG_CLOSE_LIMIT] = 32'd2;
                phase_regs[CFG_PROBE_LIMIT] = 32'd2;
                phase_regs[CFG_WINDOW]      = 32'd2000;
            end
            1:
            begin
                foreach (phase_regs[i])
                    phase_regs[i] = '0;
            end
            2:
            begin
                phase_regs[CFG_FAIL_LIMIT]  = 32'hFFFF;
                phase_regs[CFG_FAIL_RATE]   = 32'd100;
                phase_regs[CFG_OPEN_HOLD]   = 32'hFFFF_FFFF;
                phase_regs[CFG_CLOSE_LIMIT] = 32'hFFFF;
                phase_regs[CFG_PROBE_LIMIT] = 32'hFFFF;
                phase_regs[CFG_WINDOW]      = 32'hFFFF_FFFF;
            end
            default:
            begin
                // Junk in the unused upper bits must not reach the registers.
                phase_regs[CFG_FAIL_LIMIT]  = {16'($urandom()), 16'($urandom_range(1, 8))};
                phase_regs[CFG_FAIL_RATE]   = {25'($urandom()),
                                               7'((p == 3) ? 127 : $urandom_range(0, 100))};
                phase_regs[CFG_OPEN_HOLD]   = $urandom_range(0, 1000);
                phase_regs[CFG_CLOSE_LIMIT] = {16'($urandom()), 16'($urandom_range(1, 5))};
                phase_regs[CFG_PROBE_LIMIT] = {16'($urandom()), 16'($urandom_range(1, 5))};
                phase_regs[CFG_WINDOW]      = $urandom_range(50, 5000);
            end
        endcase
    endtask

    // One random event. Time mostly creeps forward, sometimes jumps past the
    // hold or the window, goes back, or lands anywhere in the 48-bit range.
    // The operation mix follows the predicted state so that the breaker keeps
    // cycling through open, half-open and closed.
    function automatic cb_evt_t pick_event();
        cb_evt_t    ev;
        int         r;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms += TIME_BITS'($urandom_range(0, tick));
        else if (r < 85)
            clock_ms += TIME_BITS'(hold_ms) + TIME_BITS'($urandom_range(0, tick));
        else if (r < 92)
            clock_ms += TIME_BITS'(win_ms) + TIME_BITS'($urandom_range(0, tick));
        else if (r < 97)
            clock_ms -= TIME_BITS'($urandom_range(0, tick));
        else
            clock_ms = {16'($urandom()), 32'($urandom())};
        if (pr_state == BRK_OPEN && $urandom_range(0, 99) < 30)
            clock_ms += TIME_BITS'(hold_ms);

        r = $urandom_range(0, 999);
        if (r < 25)
            op = OP_FORCE;
        else if (r < 32)
            op = OP_RESET;
        else if (r < 50)
            op = ($urandom_range(0, 1) != 0) ? OP_UNUSED6 : OP_UNUSED7;
        else
        begin
            r = $urandom_range(0, 99);
            case (pr_state)
                BRK_CLOSED:
                    op = (r < 30) ? OP_REQUEST : (r < 55) ? OP_SUCCESS :
                         (r < 90) ? OP_FAILURE : OP_TIMEOUT;
                BRK_OPEN:
                    op = (r < 60) ? OP_REQUEST : (r < 80) ? OP_SUCCESS :
                         (r < 95) ? OP_FAILURE : OP_TIMEOUT;
                default:
                    op = (r < 40) ? OP_REQUEST : (r < 75) ? OP_SUCCESS :
                         (r < 95) ? OP_FAILURE : OP_TIMEOUT;
            endcase
        end
        ev.operation    = op;
        ev.now_ms       = clock_ms;
        ev.forced_state = 2'($urandom_range(0, 3));
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver stall and result checking
    // ------------------------------------------------------------------------

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat %0h with nothing expected", res_data));
            else
            begin
                cb_res_t want;
                want = pending_results.pop_front();
                check_field("allowed", res_data.allowed, want.allowed);
                check_field("breaker_state", res_data.breaker_state, want.breaker_state);
                check_field("window_entries", res_data.window_entries, want.window_entries);
                check_field("window_failures", res_data.window_failures,
                            want.window_failures);
                check_field("fail_streak", res_data.fail_streak, want.fail_streak);
                check_field("success_streak", res_data.success_streak, want.success_streak);
                check_field("requests_seen", res_data.requests_seen, want.requests_seen);
                check_field("successes_seen", res_data.successes_seen, want.successes_seen);
                check_field("failures_seen", res_data.failures_seen, want.failures_seen);
                check_field("rejections_seen", res_data.rejections_seen,
                            want.rejections_seen);
                check_field("timeouts_seen", res_data.timeouts_seen, want.timeouts_seen);
                check_field("transitions_seen", res_data.transitions_seen,
                            want.transitions_seen);
            end
            results_checked++;
        end
    end

    // Watchdog: ends the run when no handshake of any kind completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        cb_evt_t ev;
        int      counted;

        // Register defaults and cleared state, as the block has after reset.
        lim_fail  = 16'd5;
        lim_rate  = 7'd50;
        hold_ms   = 32'd30000;
        lim_close = 16'd3;
        lim_probe = 16'd3;
        win_ms    = 32'd60000;
        clear_breaker('0);

        send_gap_pct = 22;
        stall_pct    = 76;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table under the reset register values.
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            ev.operation    = PLAN[i].op;
            ev.now_ms       = PLAN[i].stamp;
            ev.forced_state = PLAN[i].target;
            send_event(ev, 1'b1, PLAN[i].allow, PLAN[i].state);
        end

        // Random phases, each with fresh register settings written while idle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p < 3)
            begin
                send_gap_pct = 22;
                stall_pct    = 76;
            end
            else if (p < 6)
            begin
                send_gap_pct = 76;
                stall_pct    = 22;
            end
            else
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            load_phase_regs(p);
            write_regs(p[0]);
            tick = (win_ms >> 8) + (hold_ms >> 6) + 32'd1;

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                ev = pick_event();
                send_event(ev, 1'b0, 1'b0, BRK_CLOSED);
                if (!(ev.operation > OP_RESET ||
                      (ev.operation == OP_FORCE && ev.forced_state == FORCE_BAD)))
                    counted++;
                // Now and then let the block run dry in mid-phase.
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end

        // Collect the remaining results, then watch for stray beats.
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d events (%0d from the directed table), %0d result beats",
                 events_sent, PLAN_ROWS, results_checked);
        $display("and %0d register writes; %0d opens, %0d half-open entries, %0d closes, %0d %s",
                 reg_writes, opens, half_entries, closes, full_drops,
                 $sformatf("full-ring drops, %0d expired entries.", expired_pops));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches found", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
